FILE: rtl/cfig_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfig_pkg
// Shared types and constants of the covariance feature image generator.
// ----------------------------------------------------------------------------
package cfig_pkg;

   localparam int PIX_W     = 8;
   localparam int POS_W     = 10;
   localparam int GRAD_W    = 9;
   localparam int SEC_W     = 10;
   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 1;
   localparam int TDATA_W   = 72;

   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = 2;
   localparam int Q_CNT_W   = 3;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd480;

   // which rows and columns of the window fall due for one pixel
   typedef struct packed {
      logic row_on;
      logic row_first;
      logic row_last;
      logic col_on;
      logic col_first;
      logic col_last;
   } span_type;

   // one column of the neighbourhood plus where its results land
   typedef struct packed {
      logic [PIX_W-1:0] pix_top;
      logic [PIX_W-1:0] pix_mid;
      logic [PIX_W-1:0] pix_bot;
      logic [POS_W-1:0] col_base;
      logic [POS_W-1:0] row_base;
      span_type         span;
   } entry_type;

endpackage

FILE: rtl/cfig_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfig_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module cfig_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/cfig_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfig_front
// Takes pixels, tracks position, classifies which results fall due and
// fetches the column above from the two line stores.
// ----------------------------------------------------------------------------
module cfig_front
   import cfig_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [$clog2(MAX_WIDTH):0]    width_eff,
   input  logic [$clog2(MAX_HEIGHT):0]   height_eff,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [PIX_W-1:0]              req_tdata,
   output logic                          push_valid,
   input  logic                          push_ready,
   output entry_type                     push_entry
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int CPW = (CW > POS_W) ? CW : POS_W;
   localparam int RPW = (RW > POS_W) ? RW : POS_W;

   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [CW-1:0]    s1_col_ff;
   logic [POS_W-1:0] s1_col_base_ff, s1_row_base_ff;
   span_type         s1_span_ff, span_now;
   logic [PIX_W-1:0] older_rd, newer_rd;
   logic             accept, push;
   logic [CPW-1:0]   col_wide, col_base_wide;
   logic [RPW-1:0]   row_wide, row_base_wide;
   logic [CW:0]      col_next;
   logic [RW:0]      row_next;

   assign accept      = req_tvalid && req_tready;
   assign push        = s1_valid_ff && push_ready;
   assign req_tready  = !s1_valid_ff || push_ready;
   assign push_valid  = s1_valid_ff;

   assign col_next = {1'b0, col_ff} + (CW+1)'(1);
   assign row_next = {1'b0, row_ff} + (RW+1)'(1);

   // classification of the incoming pixel
   always_comb begin
      span_now.row_on    = ({1'b0, row_ff} >= (RW+1)'(2));
      span_now.row_first = ({1'b0, row_ff} == (RW+1)'(2));
      span_now.row_last  = span_now.row_on && ({1'b0, row_ff} == height_eff - (RW+1)'(1));
      span_now.col_on    = ({1'b0, col_ff} >= (CW+1)'(2));
      span_now.col_first = ({1'b0, col_ff} == (CW+1)'(2));
      span_now.col_last  = span_now.col_on && ({1'b0, col_ff} == width_eff - (CW+1)'(1));
   end

   assign col_wide      = CPW'(col_ff);
   assign row_wide      = RPW'(row_ff);
   assign col_base_wide = col_wide - CPW'(2);
   assign row_base_wide = row_wide - RPW'(2);

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         if (col_next >= width_eff) begin
            col_in = '0;
            row_in = (row_next >= height_eff) ? '0 : row_next[RW-1:0];
         end else begin
            col_in = col_next[CW-1:0];
         end
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff      <= req_tdata;
         s1_col_ff      <= col_ff;
         s1_col_base_ff <= col_base_wide[POS_W-1:0];
         s1_row_base_ff <= row_base_wide[POS_W-1:0];
         s1_span_ff     <= span_now;
      end
   end

   // rows r-2 and r-1 of this column; both stores rotate on the transfer
   cfig_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_row (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (s1_col_ff),
      .wr_data (newer_rd),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (older_rd)
   );

   cfig_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer_row (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (newer_rd)
   );

   always_comb begin
      push_entry.pix_top  = older_rd;
      push_entry.pix_mid  = newer_rd;
      push_entry.pix_bot  = s1_pix_ff;
      push_entry.col_base = s1_col_base_ff;
      push_entry.row_base = s1_row_base_ff;
      push_entry.span     = s1_span_ff;
   end

endmodule

FILE: rtl/cfig_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfig_queue
// Short register queue of window columns between front and back.
// ----------------------------------------------------------------------------
module cfig_queue
   import cfig_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      pop_valid,
   input  logic      pop,
   output entry_type pop_entry
);

   entry_type          slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_entry  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/cfig_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfig_back
// Holds the 3x3 window and emits the due feature vectors one per cycle
// through an output register, as long as rsp_tready does not stall it.
// ----------------------------------------------------------------------------
module cfig_back
   import cfig_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop,
   input  entry_type          pop_entry,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,
   output logic               rsp_tlast
);

   logic [PIX_W-1:0]   win_ff [3][3];
   logic               busy_ff, busy_in;
   entry_type          cur_ff;
   logic [1:0]         wr_ff, wr_in, wc_ff, wc_in, k_ff, k_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TDATA_W-1:0] rsp_data_ff;
   logic               rsp_last_ff;
   logic               can_load, emit, last_pair, finish;
   logic [1:0]         cur_re, cur_cs, cur_ce, new_rs, new_cs;
   logic [PIX_W-1:0]   h0, h1, h2, v0, v1, v2, centre;
   logic [GRAD_W-1:0]  gx, gy;
   logic [SEC_W-1:0]   sx, sy;
   logic [POS_W-1:0]   pos_col, pos_row;
   logic [TDATA_W-1:0] packed_data;

   assign cur_re = cur_ff.span.row_last  ? 2'd2 : 2'd1;
   assign cur_cs = cur_ff.span.col_first ? 2'd0 : 2'd1;
   assign cur_ce = cur_ff.span.col_last  ? 2'd2 : 2'd1;
   assign new_rs = pop_entry.span.row_first ? 2'd0 : 2'd1;
   assign new_cs = pop_entry.span.col_first ? 2'd0 : 2'd1;

   assign can_load  = !rsp_valid_ff || rsp_tready;
   assign emit      = busy_ff && can_load;
   // at most four results per pixel, the rest are dropped
   assign last_pair = ((wr_ff == cur_re) && (wc_ff == cur_ce)) || (k_ff == 2'd3);
   assign finish    = emit && last_pair;
   assign pop       = pop_valid && (!busy_ff || finish);

   // row of the window through the selected pixel
   always_comb begin
      case (wr_ff)
         2'd0: begin
            h0 = win_ff[0][0]; h1 = win_ff[0][1]; h2 = win_ff[0][2];
         end
         2'd1: begin
            h0 = win_ff[1][0]; h1 = win_ff[1][1]; h2 = win_ff[1][2];
         end
         default: begin
            h0 = win_ff[2][0]; h1 = win_ff[2][1]; h2 = win_ff[2][2];
         end
      endcase
   end

   // column of the window through the selected pixel
   always_comb begin
      case (wc_ff)
         2'd0: begin
            v0 = win_ff[0][0]; v1 = win_ff[1][0]; v2 = win_ff[2][0]; centre = h0;
         end
         2'd1: begin
            v0 = win_ff[0][1]; v1 = win_ff[1][1]; v2 = win_ff[2][1]; centre = h1;
         end
         default: begin
            v0 = win_ff[0][2]; v1 = win_ff[1][2]; v2 = win_ff[2][2]; centre = h2;
         end
      endcase
   end

   assign gx = {1'b0, h2} - {1'b0, h0};
   assign gy = {1'b0, v2} - {1'b0, v0};
   assign sx = {2'b00, h0} + {2'b00, h2} - {1'b0, h1, 1'b0};
   assign sy = {2'b00, v0} + {2'b00, v2} - {1'b0, v1, 1'b0};
   assign pos_col = cur_ff.col_base + POS_W'(wc_ff);
   assign pos_row = cur_ff.row_base + POS_W'(wr_ff);

   assign packed_data = {6'd0, sy, sx, gy, gx, centre, pos_row, pos_col};

   always_comb begin
      busy_in      = busy_ff;
      wr_in        = wr_ff;
      wc_in        = wc_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         k_in         = k_ff + 2'd1;
         if (wc_ff == cur_ce) begin
            wc_in = cur_cs;
            wr_in = wr_ff + 2'd1;
         end else begin
            wc_in = wc_ff + 2'd1;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (pop) begin
         busy_in = pop_entry.span.row_on && pop_entry.span.col_on;
         wr_in   = new_rs;
         wc_in   = new_cs;
         k_in    = 2'd0;
      end else if (finish) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wr_ff        <= '0;
         wc_ff        <= '0;
         k_ff         <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_ff        <= wr_in;
         wc_ff        <= wc_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= packed_data;
         rsp_last_ff <= last_pair;
      end
      if (pop) begin
         cur_ff <= pop_entry;
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= pop_entry.pix_top;
         win_ff[1][2] <= pop_entry.pix_mid;
         win_ff[2][2] <= pop_entry.pix_bot;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: rtl/covariance_feature_image_gen_core.sv
`timescale 1ns / 1ps
// latency: pixel to result through front stage, queue slot, window and output registers
// throughput: one pixel per cycle while rsp_tready stays high and each pixel causes
//   at most one result; a pixel's n results (up to 4) hold the back end, one per cycle
// reset: position counters, queue and handshakes clear, frame size returns to 640 x 480;
//   line stores and window are not cleared
// ----------------------------------------------------------------------------
// covariance_feature_image_gen_core
// Grayscale region-covariance feature generator: position, intensity and
// first and second differences for pixels of a raster stream, at most four per input pixel.
// ----------------------------------------------------------------------------
module covariance_feature_image_gen_core
   import cfig_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [PIX_W-1:0]     req_tdata,  // [7:0] pixel_value
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [9:0] out_col, [19:10] out_row, [27:20] out_intensity, [36:28] grad_x_doubled,
   // [45:37] grad_y_doubled, [55:46] second_x, [65:56] second_y, [71:66] zero
   output logic [TDATA_W-1:0]   rsp_tdata,
   output logic                 rsp_tlast   // last_of_run
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int SWW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
   localparam int SWH = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

   logic [CFG_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [SWW-1:0]   width_wide;
   logic [SWH-1:0]   height_wide;
   logic [CW:0]      width_eff;
   logic [RW:0]      height_eff;
   logic             csr_write;
   logic             push_valid, push_ready, pop_valid, pop;
   entry_type        push_entry, pop_entry;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_index)
            REG_FRAME_WIDTH:  width_in  = csr_data;
            REG_FRAME_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RESET;
         height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // frame size clamped to 3 .. maximum
   assign width_wide  = SWW'(width_ff);
   assign height_wide = SWH'(height_ff);

   always_comb begin
      if (width_wide < SWW'(3)) begin
         width_eff = (CW+1)'(3);
      end else if (width_wide > SWW'(MAX_WIDTH)) begin
         width_eff = (CW+1)'(MAX_WIDTH);
      end else begin
         width_eff = width_wide[CW:0];
      end
      if (height_wide < SWH'(3)) begin
         height_eff = (RW+1)'(3);
      end else if (height_wide > SWH'(MAX_HEIGHT)) begin
         height_eff = (RW+1)'(MAX_HEIGHT);
      end else begin
         height_eff = height_wide[RW:0];
      end
   end

   cfig_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock      (clock),
      .reset      (reset),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   cfig_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   cfig_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the grayscale covariance feature generator. Pixels
// go in as random and hand-picked frames of many sizes, frame size changes
// fall both between and inside frames, and every feature vector that comes
// out is checked field by field against a cycle-free model of the window,
// the line stores and the position counters.
// ----------------------------------------------------------------------------
module testbench;
   import cfig_pkg::*;

   localparam int LINE_DEPTH      = 1024;
   localparam int MAX_ROWS        = 1024;
   localparam int MAX_RESULTS     = 4;
   localparam int FEATURE_W       = 66;
   localparam int RANDOM_PIXELS   = 140;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 12;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int MAX_REPORTS     = 30;

   // laid out as on rsp_tdata, with tlast on top
   typedef struct packed {
      logic                     last_of_run;
      logic signed [SEC_W-1:0]  second_y;
      logic signed [SEC_W-1:0]  second_x;
      logic signed [GRAD_W-1:0] grad_y_doubled;
      logic signed [GRAD_W-1:0] grad_x_doubled;
      logic [PIX_W-1:0]         out_intensity;
      logic [POS_W-1:0]         out_row;
      logic [POS_W-1:0]         out_col;
   } feature_type;

   class feature_scoreboard;
      logic [CFG_W-1:0] width_reg;
      logic [CFG_W-1:0] height_reg;
      logic [PIX_W-1:0] older_line [LINE_DEPTH];
      logic [PIX_W-1:0] newer_line [LINE_DEPTH];
      logic [PIX_W-1:0] window_pix [3][3];
      int unsigned      col_pos;
      int unsigned      row_pos;
      feature_type      pending_features [$];
      int               errors;

      function void clear();
         width_reg  = FRAME_WIDTH_RESET;
         height_reg = FRAME_HEIGHT_RESET;
         col_pos    = 0;
         row_pos    = 0;
         errors     = 0;
         pending_features.delete();
      endfunction

      function int unsigned fit_size(logic [CFG_W-1:0] v, int unsigned hi);
         if (v < 3) return 3;
         if (v > hi) return hi;
         return v;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
         if (idx == REG_FRAME_WIDTH)
            width_reg = data;
         else
            height_reg = data;
      endfunction

      function int pending_count();
         return pending_features.size();
      endfunction

      // one accepted pixel: slide the window, update the line stores, queue what falls due
      function void predict_pixel(logic [PIX_W-1:0] px);
         int unsigned w, h, c, r, ci, total, n;
         int          row_sel [$];
         int          col_sel [$];
         int          i, j, wr, wc;
         feature_type f;
         w  = fit_size(width_reg, LINE_DEPTH);
         h  = fit_size(height_reg, MAX_ROWS);
         c  = col_pos;
         r  = row_pos;
         ci = c % LINE_DEPTH;
         for (i = 0; i < 3; i++) begin
            window_pix[i][0] = window_pix[i][1];
            window_pix[i][1] = window_pix[i][2];
         end
         window_pix[0][2] = older_line[ci];
         window_pix[1][2] = newer_line[ci];
         window_pix[2][2] = px;
         older_line[ci]   = newer_line[ci];
         newer_line[ci]   = px;

         if (r >= 2) begin
            if (r == 2) row_sel.push_back(0);
            row_sel.push_back(1);
            if (r == h - 1) row_sel.push_back(2);
         end
         if (c >= 2) begin
            if (c == 2) col_sel.push_back(0);
            col_sel.push_back(1);
            if (c == w - 1) col_sel.push_back(2);
         end
         // narrow frames can owe more than four; the surplus is dropped
         total = row_sel.size() * col_sel.size();
         if (total > MAX_RESULTS) total = MAX_RESULTS;
         n = 0;
         for (i = 0; i < row_sel.size(); i++) begin
            for (j = 0; j < col_sel.size(); j++) begin
               if (n < total) begin
                  wr = row_sel[i];
                  wc = col_sel[j];
                  f.out_col        = POS_W'(c - 2 + wc);
                  f.out_row        = POS_W'(r - 2 + wr);
                  f.out_intensity  = window_pix[wr][wc];
                  f.grad_x_doubled = GRAD_W'(int'(window_pix[wr][2]) - int'(window_pix[wr][0]));
                  f.grad_y_doubled = GRAD_W'(int'(window_pix[2][wc]) - int'(window_pix[0][wc]));
                  f.second_x       = SEC_W'(int'(window_pix[wr][0]) + int'(window_pix[wr][2])
                                            - 2 * int'(window_pix[wr][1]));
                  f.second_y       = SEC_W'(int'(window_pix[0][wc]) + int'(window_pix[2][wc])
                                            - 2 * int'(window_pix[1][wc]));
                  f.last_of_run    = (n == total - 1);
                  pending_features.push_back(f);
                  n++;
               end
            end
         end

         if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
         end else begin
            col_pos = c + 1;
         end
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            if (errors < MAX_REPORTS)
               $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_feature(logic [TDATA_W-1:0] data, logic tlast);
         feature_type got;
         feature_type want;
         got = {tlast, data[FEATURE_W-1:0]};
         if (pending_features.size() == 0) begin
            if (errors < MAX_REPORTS)
               $error("result with nothing expected: col %0d row %0d",
                      got.out_col, got.out_row);
            errors++;
            return;
         end
         want = pending_features.pop_front();
         compare_field("out_col", want.out_col, got.out_col);
         compare_field("out_row", want.out_row, got.out_row);
         compare_field("out_intensity", want.out_intensity, got.out_intensity);
         compare_field("grad_x_doubled", want.grad_x_doubled, got.grad_x_doubled);
         compare_field("grad_y_doubled", want.grad_y_doubled, got.grad_y_doubled);
         compare_field("second_x", want.second_x, got.second_x);
         compare_field("second_y", want.second_y, got.second_y);
         compare_field("last_of_run", want.last_of_run, got.last_of_run);
         compare_field("tdata padding", 0, data[TDATA_W-1:FEATURE_W]);
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [PIX_W-1:0]     req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [TDATA_W-1:0]   rsp_tdata;
   logic                 rsp_tlast;

   feature_scoreboard scoreboard = new;
   logic              idle_on      = 1'b1;
   logic              hold_request = 1'b0;
   int                quiet_cycles = 0;

   covariance_feature_image_gen_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // every transfer is seen here, at the edge that completes it
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) scoreboard.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready) scoreboard.predict_pixel(req_tdata);
         if (rsp_tvalid && rsp_tready) scoreboard.check_feature(rsp_tdata, rsp_tlast);
      end
   end

   always @(posedge clock) begin
      if (reset || (csr_valid && csr_ready) || (req_tvalid && req_tready)
          || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         rsp_tready <= !(idle_on && $urandom_range(99) < 6);
         @(posedge clock);
      end
   end

   // valid stays high from one pixel to the next unless a gap is drawn
   task automatic send_pixel(input logic [PIX_W-1:0] px);
      if (idle_on && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_pixel(PIX_W'($urandom_range(255)));
   endtask

   // pixels that owe nothing may still be in flight, hence the extra cycles
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (scoreboard.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= REG_FRAME_WIDTH;
      csr_data  <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= REG_FRAME_HEIGHT;
      csr_data  <= h;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [PIX_W-1:0] checker_pix [9];
      logic [PIX_W-1:0] ramp_pix [9];
      int               frame_w, frame_h, sent, frame_no;

      checker_pix = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0};
      ramp_pix    = '{8'd0, 8'd128, 8'd255, 8'd128, 8'd128, 8'd128, 8'd255, 8'd128, 8'd0};
      scoreboard.clear();
      reset      <= 1'b1;
      csr_valid  <= 1'b0;
      csr_index  <= REG_FRAME_WIDTH;
      csr_data   <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // 3x3 frame: the corner pixel owes more than four results;
      // second differences at full swing, gradients zero
      configure(11'd3, 11'd3);
      foreach (checker_pix[i]) send_pixel(checker_pix[i]);
      // sizes below the minimum behave as 3
      configure(11'd0, 11'd2);
      foreach (ramp_pix[i]) send_pixel(ramp_pix[i]);

      sent     = 0;
      frame_no = 0;
      frame_w  = 3;
      frame_h  = 3;
      while (sent < RANDOM_PIXELS) begin
         if (frame_no == 0 || $urandom_range(2) != 0) begin
            if ($urandom_range(7) == 0) begin
               frame_w = 3;
               frame_h = 3;
               configure(CFG_W'($urandom_range(2)), CFG_W'($urandom_range(2)));
            end else begin
               frame_w = $urandom_range(12, 3);
               frame_h = $urandom_range(8, 3);
               configure(CFG_W'(frame_w), CFG_W'(frame_h));
            end
         end
         idle_on = !(sent >= 40 && sent < 120);
         // block fills and stalls its input while results are held back
         if (frame_no == 1) hold_request = 1'b1;
         send_random(frame_w * frame_h);
         sent += frame_w * frame_h;
         frame_no++;
      end
      idle_on = 1'b1;

      // height shrinks below the current row: row counter wraps at row end
      configure(11'd8, 11'd8);
      send_random(8 * 4 + 3);
      configure(11'd8, 11'd3);
      send_random(5 + 8 * 3);
      // width shrinks below the current column: column counter wraps at once
      configure(11'd8, 11'd5);
      send_random(8 * 2 + 6);
      configure(11'd4, 11'd5);
      send_random(1 + 4 * 2);

      // width register above the limit: part of the first row, then a height
      // register above the limit carries on from the next row
      configure(11'd2047, 11'd3);
      send_random(40);
      configure(11'd3, 11'd2047);
      send_random(1 + 3 * 12);

      wait_idle();
      if (scoreboard.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: sim.f
rtl/cfig_pkg.sv
rtl/cfig_ram.sv
rtl/cfig_front.sv
rtl/cfig_queue.sv
rtl/cfig_back.sv
rtl/covariance_feature_image_gen_core.sv
verif/testbench.sv
